[hdl/sra_pkg.sv]
`default_nettype none

package sra_pkg;

  // Number of stages that have coefficient registers
  localparam int REG_STAGES = 4;
  localparam int SHEAR_STAGES_DEF = 4;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int ORDER_W = 2 * REG_STAGES;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SHEAR_ORDER = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_FIRST = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_LAST = 3'd4;

  localparam logic [ORDER_W-1:0] SHEAR_ORDER_RST = 8'hFF;

  // Per-stage axis code
  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Input transaction
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } sra_in_t;

  // Output transaction
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } sra_out_t;

  // Point plus saturation flag, carried through the stage chain
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } sra_point_t;

  // Settings for one shear stage
  typedef struct packed {
    axis_t              code;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
  } sra_stage_cfg_t;

endpackage

`default_nettype wire

[hdl/sra_stage.sv]
`default_nettype none

// One shear stage, three registers deep:
//   1: pick the two other coordinates and multiply by the coefficients
//   2: round both products and add them to the sheared axis
//   3: saturate and write the axis back
module sra_stage
  import sra_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire sra_stage_cfg_t cfg,
  input  wire logic           valid_in,
  input  wire sra_point_t     pt_in,
  output logic                valid_out,
  output sra_point_t          pt_out
);

  // Step 1 operand selection
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [31:0] op_axis;

  always_comb begin
    unique case (cfg.code)
      AXIS_X: begin
        op_a = pt_in.y;
        op_b = pt_in.z;
        op_axis = pt_in.x;
      end
      AXIS_Y: begin
        op_a = pt_in.x;
        op_b = pt_in.z;
        op_axis = pt_in.y;
      end
      AXIS_Z: begin
        op_a = pt_in.x;
        op_b = pt_in.y;
        op_axis = pt_in.z;
      end
      default: begin
        op_a = pt_in.y;
        op_b = pt_in.z;
        op_axis = pt_in.x;
      end
    endcase
  end

  // Step 1 registers
  logic               v1;
  sra_point_t         pt1;
  axis_t              code1;
  logic signed [31:0] axis1;
  logic signed [63:0] prod_a;
  logic signed [63:0] prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1 <= pt_in;
      code1 <= cfg.code;
      axis1 <= op_axis;
      prod_a <= op_a * cfg.c0;
      prod_b <= op_b * cfg.c1;
    end
  end

  // Step 2: round to nearest (ties up) is floor(p / 2^26) plus bit 25
  logic [37:0] rnd_a;
  logic [37:0] rnd_b;
  logic [39:0] sum_next;

  always_comb begin
    rnd_a = prod_a[63:26] + {37'd0, prod_a[25]};
    rnd_b = prod_b[63:26] + {37'd0, prod_b[25]};
    sum_next = {{8{axis1[31]}}, axis1} + {{2{rnd_a[37]}}, rnd_a}
             + {{2{rnd_b[37]}}, rnd_b};
  end

  logic       v2;
  sra_point_t pt2;
  axis_t      code2;
  logic [39:0] sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt2 <= pt1;
      code2 <= code1;
      sum2 <= sum_next;
    end
  end

  // Step 3: clip to 32 bits and write back
  logic        clip_hi;
  logic        clip_lo;
  logic [31:0] clipped;
  sra_point_t  pt_next;

  always_comb begin
    clip_hi = !sum2[39] && (sum2[38:31] != 8'h00);
    clip_lo = sum2[39] && (sum2[38:31] != 8'hFF);
    if (clip_hi) begin
      clipped = 32'h7FFF_FFFF;
    end else if (clip_lo) begin
      clipped = 32'h8000_0000;
    end else begin
      clipped = sum2[31:0];
    end
    pt_next = pt2;
    unique case (code2)
      AXIS_X: begin
        pt_next.x = clipped;
        pt_next.sat = pt2.sat | clip_hi | clip_lo;
      end
      AXIS_Y: begin
        pt_next.y = clipped;
        pt_next.sat = pt2.sat | clip_hi | clip_lo;
      end
      AXIS_Z: begin
        pt_next.z = clipped;
        pt_next.sat = pt2.sat | clip_hi | clip_lo;
      end
      default: begin
        pt_next = pt2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_out <= pt_next;
    end
  end

endmodule

`default_nettype wire

[hdl/shear_rotation_apply.sv]
`default_nettype none

// Rotates a 3D point (signed Q16.16) by a chain of axis shears whose axis codes
// and Q5.26 coefficient pairs are written by software. Each shear stage is a
// three-register pipeline (multiply, round and add, saturate), and one point can
// enter every cycle while no result is held by an output stall. The last stage
// register doubles as the output register; when a valid result meets out_stall,
// the whole pipeline holds and in_stall is raised.
// Write the configuration only while no transaction is in flight.
module shear_rotation_apply
  import sra_pkg::*;
#(
  parameter int SHEAR_STAGES = SHEAR_STAGES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_DATA_W-1:0]  wr_data,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire sra_in_t                in_data,
  // output channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output sra_out_t                    out_data
);

  // Stages past the registered ones act as no shear and need no hardware
  localparam int ACTIVE = (SHEAR_STAGES < REG_STAGES) ? SHEAR_STAGES : REG_STAGES;

  // Configuration registers
  logic [ORDER_W-1:0]    shear_order;
  logic [CFG_DATA_W-1:0] coeffs [REG_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      shear_order <= SHEAR_ORDER_RST;
      for (int i = 0; i < REG_STAGES; i++) begin
        coeffs[i] <= '0;
      end
    end else if (wr_en) begin
      if (wr_index == REG_SHEAR_ORDER) begin
        shear_order <= wr_data[ORDER_W-1:0];
      end else if (wr_index >= REG_COEFF_FIRST && wr_index <= REG_COEFF_LAST) begin
        coeffs[2'(wr_index - REG_COEFF_FIRST)] <= wr_data;
      end
    end
  end

  // Global advance: move unless a finished result is held
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage chain
  logic       chain_valid [ACTIVE+1];
  sra_point_t chain_pt    [ACTIVE+1];

  assign chain_valid[0] = in_valid;
  assign chain_pt[0] = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z, sat: 1'b0};

  for (genvar s = 0; s < ACTIVE; s++) begin : g_stage
    sra_stage_cfg_t stage_cfg;

    assign stage_cfg.code = axis_t'(shear_order[2*s +: 2]);
    assign stage_cfg.c0 = coeffs[s][31:0];
    assign stage_cfg.c1 = coeffs[s][63:32];

    sra_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .cfg       (stage_cfg),
      .valid_in  (chain_valid[s]),
      .pt_in     (chain_pt[s]),
      .valid_out (chain_valid[s+1]),
      .pt_out    (chain_pt[s+1])
    );
  end

  // Result
  assign out_valid = chain_valid[ACTIVE];
  assign out_data.out_x = chain_pt[ACTIVE].x;
  assign out_data.out_y = chain_pt[ACTIVE].y;
  assign out_data.out_z = chain_pt[ACTIVE].z;
  assign out_data.saturated = chain_pt[ACTIVE].sat;

endmodule

`default_nettype wire
